[src/fkw_pkg.sv]
// -----------------------------------------------------------------------------
// fkw_pkg
// Shared constants, types and helper functions for the forbidden keyword
// scanner: the word list, history depth and the step record.
// -----------------------------------------------------------------------------
package fkw_pkg;

	localparam int HIST_DEPTH = 10;
	localparam int WORD_COUNT = 7;
	localparam int WORD_MAX   = HIST_DEPTH + 1;
	localparam int POS_W      = $clog2(WORD_MAX + 1);

	// Words are right-aligned: the last letter sits in bits [7:0], the letter
	// p places before the end in bits [8*p +: 8]. Padding is zero.
	localparam logic [WORD_COUNT-1:0][8*WORD_MAX-1:0] WORDS = '{
		(8*WORD_MAX)'("token"),
		(8*WORD_MAX)'("secret"),
		(8*WORD_MAX)'("credential"),
		(8*WORD_MAX)'({"backend", "_url"}),
		(8*WORD_MAX)'("ssid"),
		(8*WORD_MAX)'("passphrase"),
		(8*WORD_MAX)'("password")
	};

	localparam logic [WORD_COUNT-1:0][POS_W-1:0] WORD_LENS = '{
		POS_W'(5), POS_W'(6), POS_W'(10), POS_W'(11),
		POS_W'(4), POS_W'(10), POS_W'(8)
	};

	localparam logic [7:0] OPEN_BRACE  = 8'h7B;
	localparam logic [7:0] CLOSE_BRACE = 8'h7D;

	typedef struct packed {
		logic       accept;
		logic       last;
		logic       word_hit;
		logic [7:0] data;
	} fkw_step_t;

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	// Per-word compare of one byte against the letter pos places before the end.
	// A position beyond a word's start counts as a match.
	function automatic logic [WORD_COUNT-1:0] pos_match(input logic [7:0] c,
			input logic [POS_W-1:0] pos);
		logic [WORD_COUNT-1:0] m;
		for (int w = 0; w < WORD_COUNT; w++) begin
			if (pos >= WORD_LENS[w]) begin
				m[w] = 1'b1;
			end else begin
				m[w] = (c == WORDS[w][8*pos +: 8]);
			end
		end
		return m;
	endfunction

endpackage

[src/fkw_if.sv]
// -----------------------------------------------------------------------------
// fkw_if
// Valid/ready channels of the scanner: text bytes in, verdict out.
// -----------------------------------------------------------------------------
interface fkw_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source(output valid, output data_byte, output end_of_text, input ready);
	modport sink(input valid, input data_byte, input end_of_text, output ready);
endinterface

interface fkw_verdict_if;
	logic valid;
	logic ready;
	logic is_clean;

	modport source(output valid, output is_clean, input ready);
	modport sink(input valid, input is_clean, output ready);
endinterface

[src/forbidden_keyword_scanner.sv]
// -----------------------------------------------------------------------------
// forbidden_keyword_scanner
// Checks a byte stream for JSON-like framing and forbidden words.
// -----------------------------------------------------------------------------
// Usage:
//   text    : one byte per transaction, end_of_text set on the final byte.
//   verdict : one transaction per text, is_clean = 1 when the text is at least
//             two bytes, opens with '{', closes with '}', holds no zero byte
//             and contains none of password, passphrase, ssid, the backend
//             url key, credential, secret, token (ASCII case ignored).
// Throughput: one byte per cycle unless a verdict waits. Each byte is compared
//   in the same cycle against a row of ten history cells, each comparing its
//   byte with the letter of every word at its distance from the end.
// Output: registered; valid in the cycle after the final byte is taken.
// Stall: the verdict sits in an output register; while it waits untaken,
//   text.ready is low and no byte is taken. In the cycle the verdict is
//   accepted, text.ready is high again, so texts can follow with no gap.
// Reset: history and frame flags clear, no verdict pending. They clear again
//   after every final byte, so no word matches across two texts.
// -----------------------------------------------------------------------------
module forbidden_keyword_scanner (
	input  logic          clk,
	input  logic          arst_n,
	fkw_text_if.sink      text,
	fkw_verdict_if.source verdict
);

	localparam int DEPTH = fkw_pkg::HIST_DEPTH;
	localparam int WC    = fkw_pkg::WORD_COUNT;

	logic [7:0]          lc;
	logic                in_ready;
	logic                accept;
	logic [DEPTH:0][7:0] chain;
	logic [DEPTH:0][WC-1:0] hits;
	logic [WC-1:0]       all_hit;
	fkw_pkg::fkw_step_t  step;

	assign text.ready = in_ready;
	assign accept     = text.valid && in_ready;
	assign lc         = fkw_pkg::to_lower(text.data_byte);

	assign chain[0] = lc;
	assign hits[0]  = fkw_pkg::pos_match(lc, fkw_pkg::POS_W'(0));

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		fkw_cell #(
			.POS(i + 1)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (accept && !text.end_of_text),
			.clear (accept && text.end_of_text),
			.d     (chain[i]),
			.q     (chain[i+1]),
			.hit   (hits[i+1])
		);
	end

	always_comb begin
		all_hit = '1;
		for (int i = 0; i <= DEPTH; i++) begin
			all_hit = all_hit & hits[i];
		end
	end

	assign step.accept   = accept;
	assign step.last     = text.end_of_text;
	assign step.word_hit = |all_hit;
	assign step.data     = text.data_byte;

	fkw_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_ready(in_ready),
		.verdict (verdict)
	);

endmodule

[src/fkw_cell.sv]
// -----------------------------------------------------------------------------
// fkw_cell
// One history cell: holds one lower-cased byte, passes it on to the next
// cell on every shift and compares it against each word at its position.
// -----------------------------------------------------------------------------
module fkw_cell #(
	parameter int POS = 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift,
	input  logic                           clear,
	input  logic [7:0]                     d,
	output logic [7:0]                     q,
	output logic [fkw_pkg::WORD_COUNT-1:0] hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= d;
		end
	end

	assign q   = byte_q;
	assign hit = fkw_pkg::pos_match(byte_q, fkw_pkg::POS_W'(POS));

endmodule

[src/fkw_frame.sv]
// -----------------------------------------------------------------------------
// fkw_frame
// Frame flags of the current text and the verdict output register.
// -----------------------------------------------------------------------------
module fkw_frame (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fkw_pkg::fkw_step_t    step,
	output logic                  in_ready,
	fkw_verdict_if.source         verdict
);

	logic any_q, bad_q, zero_q, found_q;
	logic valid_q, clean_q;
	logic clean;

	assign in_ready = !valid_q || verdict.ready;

	assign clean = any_q && !bad_q && !zero_q && !found_q && !step.word_hit
		&& step.data == fkw_pkg::CLOSE_BRACE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q   <= 1'b0;
			bad_q   <= 1'b0;
			zero_q  <= 1'b0;
			found_q <= 1'b0;
		end else if (step.accept) begin
			if (step.last) begin
				any_q   <= 1'b0;
				bad_q   <= 1'b0;
				zero_q  <= 1'b0;
				found_q <= 1'b0;
			end else begin
				any_q <= 1'b1;
				if (!any_q && step.data != fkw_pkg::OPEN_BRACE) begin
					bad_q <= 1'b1;
				end
				if (step.data == 8'h00) begin
					zero_q <= 1'b1;
				end
				if (step.word_hit) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step.accept && step.last) begin
			valid_q <= 1'b1;
		end else if (verdict.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.accept && step.last) begin
			clean_q <= clean;
		end
	end

	assign verdict.valid    = valid_q;
	assign verdict.is_clean = clean_q;

endmodule
